// File: rtl/core/mac_pkg.sv
// Shared types and constants for the moving average crossover detector.
// Used by the channel interfaces and by the top level; depends on nothing.
package mac_pkg;

    // Configuration port
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WINDOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_WINDOW = 1'b1;
    localparam logic [CFG_W-1:0] LONG_WINDOW_RST  = 9'd10;
    localparam logic [CFG_W-1:0] SHORT_WINDOW_RST = 9'd5;

    // Channel payload widths
    localparam int SAMPLE_W = 32;
    localparam int SIGNAL_W = 2;

    // Relation of the long average to the short one
    localparam logic [1:0] REL_EQUAL = 2'd0;
    localparam logic [1:0] REL_ABOVE = 2'd1;
    localparam logic [1:0] REL_BELOW = 2'd2;

    // Signal codes
    localparam logic [SIGNAL_W-1:0] SIG_HOLD = 2'd0;
    localparam logic [SIGNAL_W-1:0] SIG_BUY  = 2'd1;
    localparam logic [SIGNAL_W-1:0] SIG_SELL = 2'd2;

    typedef struct packed {
        logic [SIGNAL_W-1:0] signal;
        logic                window_full;
    } result_t;

endpackage

// File: rtl/core/mac_sample_if.sv
// Input channel: one price sample per transfer.
// Depends on mac_pkg for the payload width.
interface mac_sample_if;
    logic                          valid;
    logic                          ready;
    logic [mac_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// File: rtl/core/mac_result_if.sv
// Output channel: one crossover signal per transfer.
// Depends on mac_pkg for the payload width.
interface mac_result_if;
    logic                          valid;
    logic                          ready;
    logic [mac_pkg::SIGNAL_W-1:0]  signal;
    logic                          window_full;

    modport source (output valid, output signal, output window_full, input ready);
    modport sink   (input valid, input signal, input window_full, output ready);
endinterface

// File: rtl/core/mac_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependency.
module mac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/moving_average_crossover.sv
// Moving average crossover detector, top level.
// Depends on mac_pkg, mac_sample_if, mac_result_if and mac_ram.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    sample[31:0]
//  out_ch    out  valid / ready    signal[1:0], window_full
//  cfg       in   cfg_we           cfg_index[0], cfg_data[8:0]
//
// Input spacing: no sample is accepted while one is in stage 1, as the two tail
// reads (long and short window) share the single read port of the history RAM.
// Queue: results from the last pipeline stage enter a 4-entry queue.
// Reset: no clearing pass; the fill count marks history slots not yet written
// since reset or the last register write, and those read as zero.
// Stalls: input is held off while 4 results are outstanding.
module moving_average_crossover #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mac_sample_if.sink                      in_ch,
    mac_result_if.source                    out_ch,
    input  logic                            cfg_we,
    input  logic [mac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mac_pkg::CFG_W-1:0]       cfg_data
);

    localparam int DW   = (SAMPLE_BITS < mac_pkg::SAMPLE_W) ? SAMPLE_BITS : mac_pkg::SAMPLE_W;
    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int LW   = $clog2(MAX_WINDOW + 1);
    localparam int FW   = $clog2(MAX_WINDOW + 2);
    localparam int CW   = (LW > mac_pkg::CFG_W) ? LW : mac_pkg::CFG_W;
    localparam int SUMW = DW + AW;
    localparam int PW   = SUMW + LW;
    localparam int QD   = 4;
    localparam int QAW  = 2;
    localparam int QCW  = 3;

    // ---------------- configuration registers ----------------
    logic [mac_pkg::CFG_W-1:0] long_cfg_reg;
    logic [mac_pkg::CFG_W-1:0] short_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_cfg_reg  <= mac_pkg::LONG_WINDOW_RST;
            short_cfg_reg <= mac_pkg::SHORT_WINDOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mac_pkg::REG_LONG_WINDOW:  long_cfg_reg  <= cfg_data;
                mac_pkg::REG_SHORT_WINDOW: short_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // window lengths in use: zero reads as one, long capped at MAX_WINDOW, short at long
    logic [LW-1:0] long_len;
    logic [LW-1:0] short_len;

    always_comb
    begin
        logic [CW-1:0] lv;
        logic [CW-1:0] sv;
        lv = CW'(long_cfg_reg);
        sv = CW'(short_cfg_reg);
        if (lv == '0)
            lv = CW'(1);
        else if (lv > CW'(MAX_WINDOW))
            lv = CW'(MAX_WINDOW);
        if (sv == '0)
            sv = CW'(1);
        else if (sv > lv)
            sv = lv;
        long_len  = lv[LW-1:0];
        short_len = sv[LW-1:0];
    end

    // ---------------- stream state ----------------
    logic [AW-1:0]   wp_reg;
    logic [FW-1:0]   fill_reg;
    logic [SUMW-1:0] long_sum_reg;
    logic [SUMW-1:0] short_sum_reg;
    logic [1:0]      prev_rel_reg;

    // pipeline valids
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;

    // stage 1 payload (held through stage 2: no accept while stage 1 is valid)
    logic [DW-1:0] x_reg;
    logic [AW-1:0] wa_reg;
    logic [AW-1:0] si_reg;
    logic          long_ok_reg;
    logic          short_ok_reg;
    logic          full1_reg, full2_reg, full3_reg, full4_reg;
    logic [DW-1:0] long_old_reg;
    logic [PW-1:0] prod_long_reg;
    logic [PW-1:0] prod_short_reg;

    // result queue
    mac_pkg::result_t q_mem_reg [QD];
    logic [QAW-1:0]   q_wr_reg;
    logic [QAW-1:0]   q_rd_reg;
    logic [QCW-1:0]   q_cnt_reg;
    logic [QCW-1:0]   outst_reg;

    logic in_xfer;
    logic out_xfer;

    assign in_ch.ready = !s1_vld_reg && (outst_reg < QCW'(QD));
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_xfer    = out_ch.valid && out_ch.ready;

    // tail addresses and fill checks for the incoming sample
    logic [AW-1:0] li_addr;
    logic [AW-1:0] si_addr;
    logic [FW-1:0] fill_inc;

    always_comb
    begin
        logic [LW-1:0] wpe;
        logic [LW-1:0] ltap;
        logic [LW-1:0] stap;
        wpe  = LW'(wp_reg);
        ltap = (wpe >= long_len)  ? (wpe - long_len)  : (wpe + (LW'(MAX_WINDOW) - long_len));
        stap = (wpe >= short_len) ? (wpe - short_len) : (wpe + (LW'(MAX_WINDOW) - short_len));
        li_addr  = ltap[AW-1:0];
        si_addr  = stap[AW-1:0];
        fill_inc = (fill_reg == FW'(MAX_WINDOW + 1)) ? fill_reg : (fill_reg + FW'(1));
    end

    // ---------------- history RAM ----------------
    // Long tail read in the accept cycle, short tail read and write-back in
    // the next. No sample is accepted while stage 1 is valid, so the next
    // item's reads come behind this write and no forwarding path is needed.
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    assign ram_raddr = s1_vld_reg ? si_reg : li_addr;

    mac_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_WINDOW)
    ) u_hist (
        .clk   (clk),
        .we    (s1_vld_reg),
        .waddr (wa_reg),
        .wdata (x_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- stage 1 capture, pointer and fill count ----------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            x_reg        <= in_ch.sample[DW-1:0];
            wa_reg       <= wp_reg;
            si_reg       <= si_addr;
            long_ok_reg  <= fill_reg >= FW'(long_len);
            short_ok_reg <= fill_reg >= FW'(short_len);
            full1_reg    <= fill_inc >= (FW'(long_len) + FW'(1));
        end
        if (s1_vld_reg)
        begin
            long_old_reg <= ram_rdata;
            full2_reg    <= full1_reg;
        end
        if (s2_vld_reg)
        begin
            full3_reg <= full2_reg;
        end
        if (s3_vld_reg)
        begin
            prod_long_reg  <= PW'(long_sum_reg) * PW'(short_len);
            prod_short_reg <= PW'(short_sum_reg) * PW'(long_len);
            full4_reg      <= full3_reg;
        end
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_xfer;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // ---------------- running sums (stage 2) ----------------
    logic [SUMW-1:0] long_sum_next;
    logic [SUMW-1:0] short_sum_next;

    always_comb
    begin
        logic [DW-1:0] lold;
        logic [DW-1:0] sold;
        lold = long_ok_reg  ? long_old_reg : '0;
        sold = short_ok_reg ? ram_rdata    : '0;
        long_sum_next  = long_sum_reg  + SUMW'(x_reg) - SUMW'(lold);
        short_sum_next = short_sum_reg + SUMW'(x_reg) - SUMW'(sold);
    end

    // ---------------- relation and signal (stage 4) ----------------
    logic [1:0]       rel_now;
    mac_pkg::result_t res;

    always_comb
    begin
        if (prod_long_reg > prod_short_reg)
            rel_now = mac_pkg::REL_ABOVE;
        else if (prod_long_reg < prod_short_reg)
            rel_now = mac_pkg::REL_BELOW;
        else
            rel_now = mac_pkg::REL_EQUAL;

        res.window_full = full4_reg;
        res.signal      = mac_pkg::SIG_HOLD;
        if (full4_reg)
        begin
            if (prev_rel_reg == mac_pkg::REL_ABOVE && rel_now == mac_pkg::REL_BELOW)
                res.signal = mac_pkg::SIG_BUY;
            else if (prev_rel_reg == mac_pkg::REL_BELOW && rel_now == mac_pkg::REL_ABOVE)
                res.signal = mac_pkg::SIG_SELL;
        end
    end

    // stream state: any register write restarts the stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            long_sum_reg  <= '0;
            short_sum_reg <= '0;
            prev_rel_reg  <= mac_pkg::REL_EQUAL;
        end
        else if (cfg_we)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            long_sum_reg  <= '0;
            short_sum_reg <= '0;
            prev_rel_reg  <= mac_pkg::REL_EQUAL;
        end
        else
        begin
            if (in_xfer)
            begin
                wp_reg   <= (wp_reg == AW'(MAX_WINDOW - 1)) ? '0 : (wp_reg + AW'(1));
                fill_reg <= fill_inc;
            end
            if (s2_vld_reg)
            begin
                long_sum_reg  <= long_sum_next;
                short_sum_reg <= short_sum_next;
            end
            if (s4_vld_reg)
            begin
                prev_rel_reg <= rel_now;
            end
        end
    end

    // ---------------- result queue ----------------
    always_ff @(posedge clk)
    begin
        if (s4_vld_reg)
        begin
            q_mem_reg[q_wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
            outst_reg <= '0;
        end
        else
        begin
            if (s4_vld_reg)
                q_wr_reg <= q_wr_reg + QAW'(1);
            if (out_xfer)
                q_rd_reg <= q_rd_reg + QAW'(1);
            q_cnt_reg <= q_cnt_reg + QCW'(s4_vld_reg) - QCW'(out_xfer);
            outst_reg <= outst_reg + QCW'(in_xfer) - QCW'(out_xfer);
        end
    end

    assign out_ch.valid       = (q_cnt_reg != '0);
    assign out_ch.signal      = q_mem_reg[q_rd_reg].signal;
    assign out_ch.window_full = q_mem_reg[q_rd_reg].window_full;

    // ---------------- assertions ----------------
    // queue never overflows: outstanding credits cover every item in flight
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        s4_vld_reg |-> (q_cnt_reg < QCW'(QD)) || out_xfer)
        else $error("result queue overflow");

    // queued results are a subset of outstanding items
    a_outst_cover: assert property (@(posedge clk) disable iff (!rst_n)
        outst_reg >= q_cnt_reg)
        else $error("outstanding count below queue fill");

    // short tail meets the slot being written only when the short window
    // spans the whole ring; the read then returns the old sample
    a_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        s1_vld_reg && (si_reg == wa_reg) |-> (short_len == LW'(MAX_WINDOW)))
        else $error("history read/write collision");

    // an accepted item always reaches the sum update in stage 2
    a_sum_slot: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> ##1 s2_vld_reg)
        else $error("pipeline lost an item");

endmodule
